[sv/avidmx_pkg.sv]
// ---------------------------------------------------------------------------
// avidmx_pkg
// Shared codes and helpers for the AVI movi video chunk demultiplexer.
// ---------------------------------------------------------------------------
package avidmx_pkg;

    // Parse phases
    localparam logic [2:0] PH_HEADER   = 3'd0;
    localparam logic [2:0] PH_LISTTYPE = 3'd1;
    localparam logic [2:0] PH_SKIP     = 3'd2;
    localparam logic [2:0] PH_FRAME    = 3'd3;
    localparam logic [2:0] PH_PAD      = 3'd4;

    // Result status codes
    localparam logic [2:0] ST_BYTE   = 3'd0;
    localparam logic [2:0] ST_TOOBIG = 3'd1;
    localparam logic [2:0] ST_EMPTY  = 3'd2;
    localparam logic [2:0] ST_FORMAT = 3'd3;
    localparam logic [2:0] ST_END    = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_MOVI_BYTES     = 2'd0;
    localparam logic [1:0] CFG_VIDEO_STREAM   = 2'd1;
    localparam logic [1:0] CFG_FRAME_CAPACITY = 2'd2;

    // ASCII characters used in chunk ids
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_L    = 8'h4C;
    localparam logic [7:0] CH_I    = 8'h49;
    localparam logic [7:0] CH_S    = 8'h53;
    localparam logic [7:0] CH_T    = 8'h54;
    localparam logic [7:0] CH_D    = 8'h64;
    localparam logic [7:0] CH_C    = 8'h63;
    localparam logic [7:0] CH_B    = 8'h62;

    typedef logic [2:0] t_status;

    // Tens digit (0..12) of a 7-bit stream number, by threshold compares
    function automatic logic [3:0] stream_tens(input logic [6:0] vs);
        logic [3:0] tens;
        tens = 4'd0;
        for (int k = 1; k <= 12; k++) begin
            if (vs >= 7'(k * 10)) begin
                tens = 4'(k);
            end
        end
        return tens;
    endfunction

endpackage

[sv/avi_movi_video_chunk_demux_top.sv]
// Latency: a result word is registered on the clock edge that accepts its
// input byte and is offered from the next cycle on.
// Throughput: one byte per clock while the result channel is not stalled; all
// parsing for a byte is a single pass of logic between the parse-state registers and the output register.
// Reset: synchronous active low; clears parse state, config registers and the
// output valid flag.
// ---------------------------------------------------------------------------
// avi_movi_video_chunk_demux_top
// Walks the chunks of an AVI movi region byte by byte and delivers the
// payload bytes of one video stream with frame index and last marker.
// ---------------------------------------------------------------------------
module avi_movi_video_chunk_demux_top
    import avidmx_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // input byte channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_start_of_stream,
    input  logic [7:0]  i_stream_byte,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [7:0]  o_frame_byte,
    output logic [31:0] o_frame_index,
    output logic        o_last_of_frame,
    output logic [31:0] o_chunk_length
);

    // Configuration registers
    logic [31:0] r_movi_bytes;
    logic [31:0] r_frame_capacity;
    logic [7:0]  r_vid_c0;
    logic [7:0]  r_vid_c1;
    logic [3:0]  w_tens;
    logic [6:0]  w_ones;

    // Parse state
    logic [2:0]  r_phase,    n_phase;
    logic [63:0] r_shift,    n_shift;
    logic [3:0]  r_hcnt,     n_hcnt;
    logic [31:0] r_pos,      n_pos;
    logic [31:0] r_left,     n_left;
    logic        r_pad,      n_pad;
    logic [31:0] r_fcnt,     n_fcnt;
    logic [31:0] r_curlen,   n_curlen;
    logic        r_halt,     n_halt;

    // Output register
    logic        r_out_valid;
    t_status     r_status,   n_status;
    logic [7:0]  r_fbyte,    n_fbyte;
    logic [31:0] r_findex;
    logic        r_last,     n_last;
    logic [31:0] r_clen,     n_clen;
    logic        n_emit;

    // State after an optional start-of-stream clear
    logic [2:0]  s_phase;
    logic [63:0] s_shift;
    logic [3:0]  s_hcnt;
    logic [31:0] s_pos;
    logic [31:0] s_left;
    logic        s_pad;
    logic [31:0] s_fcnt;
    logic [31:0] s_curlen;
    logic        s_halt;

    // Header decode helpers
    logic [7:0]  w_c0, w_c1, w_c2, w_c3;
    logic [31:0] w_len;
    logic [33:0] w_chunk_end;
    logic        w_is_list, w_numbered, w_video;
    logic [31:0] w_left_dec;
    logic        w_accept;
    logic        w_end_hit;

    assign w_accept   = i_in_valid && o_in_ready;
    assign o_in_ready = !r_out_valid || i_out_ready;

    // Stream number to ASCII digits, worked out once per write
    assign w_tens = stream_tens(i_cfg_data[6:0]);
    assign w_ones = i_cfg_data[6:0] - 7'(w_tens) * 7'd10;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_movi_bytes     <= '0;
            r_frame_capacity <= '0;
            r_vid_c0         <= CH_ZERO;
            r_vid_c1         <= CH_ZERO;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MOVI_BYTES: begin
                    r_movi_bytes <= i_cfg_data;
                end
                CFG_VIDEO_STREAM: begin
                    r_vid_c0 <= CH_ZERO + {4'd0, w_tens};
                    r_vid_c1 <= CH_ZERO + {1'b0, w_ones};
                end
                CFG_FRAME_CAPACITY: begin
                    r_frame_capacity <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // Start of stream clears position, counters and parse state
    always_comb begin
        if (i_start_of_stream) begin
            s_phase  = PH_HEADER;
            s_shift  = '0;
            s_hcnt   = '0;
            s_pos    = '0;
            s_left   = '0;
            s_pad    = 1'b0;
            s_fcnt   = '0;
            s_curlen = '0;
            s_halt   = 1'b0;
        end else begin
            s_phase  = r_phase;
            s_shift  = r_shift;
            s_hcnt   = r_hcnt;
            s_pos    = r_pos;
            s_left   = r_left;
            s_pad    = r_pad;
            s_fcnt   = r_fcnt;
            s_curlen = r_curlen;
            s_halt   = r_halt;
        end
    end

    // Header fields as they stand once this byte is shifted in
    assign n_shift     = {i_stream_byte, s_shift[63:8]};
    assign w_c0        = n_shift[7:0];
    assign w_c1        = n_shift[15:8];
    assign w_c2        = n_shift[23:16];
    assign w_c3        = n_shift[31:24];
    assign w_len       = n_shift[63:32];
    // chunk end = (position - 7) + 8 + length
    assign w_chunk_end = {2'b00, s_pos} + 34'd1 + {2'b00, w_len};
    assign w_is_list   = (w_c0 == CH_L) && (w_c1 == CH_I) && (w_c2 == CH_S) && (w_c3 == CH_T);
    assign w_numbered  = (w_c0 inside {[CH_ZERO:CH_NINE]}) && (w_c1 inside {[CH_ZERO:CH_NINE]});
    assign w_video     = (w_c2 == CH_D) && ((w_c3 == CH_C) || (w_c3 == CH_B))
                      && (w_c0 == r_vid_c0) && (w_c1 == r_vid_c1);
    assign w_left_dec  = (s_left != '0) ? s_left - 32'd1 : s_left;
    assign w_end_hit   = (s_hcnt == '0)
                      && (({1'b0, s_pos} + 33'd8) > {1'b0, r_movi_bytes});

    // One byte of parsing
    always_comb begin
        n_phase  = s_phase;
        n_hcnt   = s_hcnt;
        n_left   = s_left;
        n_pad    = s_pad;
        n_fcnt   = s_fcnt;
        n_curlen = s_curlen;
        n_halt   = s_halt;
        n_pos    = s_pos;
        n_emit   = 1'b0;
        n_status = ST_BYTE;
        n_fbyte  = '0;
        n_last   = 1'b0;
        n_clen   = '0;

        if (!s_halt) begin
            case (s_phase)
                PH_HEADER: begin
                    if (w_end_hit) begin
                        n_halt   = 1'b1;
                        n_emit   = 1'b1;
                        n_status = ST_END;
                    end else begin
                        n_hcnt = s_hcnt + 4'd1;
                        if (s_hcnt == 4'd7) begin
                            n_hcnt = '0;
                            if (w_is_list) begin
                                n_phase = PH_LISTTYPE;
                                n_left  = 32'd4;
                            end else if (!w_numbered) begin
                                if ((w_len == '0)
                                    || (w_chunk_end > {2'b00, r_movi_bytes})) begin
                                    n_halt   = 1'b1;
                                    n_emit   = 1'b1;
                                    n_status = ST_FORMAT;
                                end else begin
                                    n_left  = w_len;
                                    n_pad   = w_len[0];
                                    n_phase = PH_SKIP;
                                end
                            end else if (w_chunk_end > ({2'b00, r_movi_bytes} + 34'd2)) begin
                                n_halt   = 1'b1;
                                n_emit   = 1'b1;
                                n_status = ST_FORMAT;
                            end else if (!w_video) begin
                                n_left  = w_len;
                                n_pad   = w_len[0];
                                n_phase = (w_len == '0) ? PH_HEADER : PH_SKIP;
                            end else begin
                                n_curlen = w_len;
                                if (w_len == '0) begin
                                    n_phase  = PH_HEADER;
                                    n_emit   = 1'b1;
                                    n_status = ST_EMPTY;
                                end else if (w_len > r_frame_capacity) begin
                                    n_emit   = 1'b1;
                                    n_status = ST_TOOBIG;
                                    n_clen   = w_len;
                                    n_fcnt   = s_fcnt + 32'd1;
                                    n_left   = w_len;
                                    n_pad    = w_len[0];
                                    n_phase  = PH_SKIP;
                                end else begin
                                    n_left  = w_len;
                                    n_pad   = w_len[0];
                                    n_phase = PH_FRAME;
                                end
                            end
                        end
                    end
                end
                PH_LISTTYPE: begin
                    n_left = w_left_dec;
                    if (w_left_dec == '0) begin
                        n_phase = PH_HEADER;
                    end
                end
                PH_SKIP: begin
                    n_left = w_left_dec;
                    if (w_left_dec == '0) begin
                        n_phase = s_pad ? PH_PAD : PH_HEADER;
                    end
                end
                PH_FRAME: begin
                    n_left   = w_left_dec;
                    n_emit   = 1'b1;
                    n_status = ST_BYTE;
                    n_fbyte  = i_stream_byte;
                    n_clen   = s_curlen;
                    n_last   = (w_left_dec == '0);
                    if (w_left_dec == '0) begin
                        n_fcnt  = s_fcnt + 32'd1;
                        n_phase = s_pad ? PH_PAD : PH_HEADER;
                    end
                end
                PH_PAD: begin
                    n_pad   = 1'b0;
                    n_phase = PH_HEADER;
                end
                default: begin
                    n_phase = PH_HEADER;
                    n_hcnt  = '0;
                end
            endcase

            // Position advances, saturating, except on the end-of-region byte
            if (!w_end_hit || (s_phase != PH_HEADER)) begin
                if (s_pos != '1) begin
                    n_pos = s_pos + 32'd1;
                end
            end
        end
    end

    // Parse-state registers, updated on each accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_shift  <= '0;
            r_hcnt   <= '0;
            r_pos    <= '0;
            r_left   <= '0;
            r_pad    <= 1'b0;
            r_fcnt   <= '0;
            r_curlen <= '0;
            r_halt   <= 1'b0;
        end else if (w_accept) begin
            r_phase  <= n_phase;
            r_shift  <= (s_halt || (s_phase != PH_HEADER) || w_end_hit) ? s_shift : n_shift;
            r_hcnt   <= n_hcnt;
            r_pos    <= n_pos;
            r_left   <= n_left;
            r_pad    <= n_pad;
            r_fcnt   <= n_fcnt;
            r_curlen <= n_curlen;
            r_halt   <= n_halt;
        end
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept && n_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && n_emit) begin
            r_status <= n_status;
            r_fbyte  <= n_fbyte;
            r_findex <= s_fcnt;
            r_last   <= n_last;
            r_clen   <= n_clen;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_frame_byte    = r_fbyte;
    assign o_frame_index   = r_findex;
    assign o_last_of_frame = r_last;
    assign o_chunk_length  = r_clen;

endmodule

[sv/avidmx_chk.sv]
// ---------------------------------------------------------------------------
// avidmx_chk
// Port-level checks on the result channel of the movi chunk demultiplexer.
// ---------------------------------------------------------------------------
module avidmx_chk
    import avidmx_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  o_status,
    input logic [7:0]  o_frame_byte,
    input logic [31:0] o_frame_index,
    input logic        o_last_of_frame,
    input logic [31:0] o_chunk_length
);

    // A stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
            && $stable(o_frame_byte) && $stable(o_frame_index)
            && $stable(o_chunk_length))
        else $error("result word changed while stalled");

    // No result word right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Status stays within its defined codes
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status <= ST_END))
        else $error("undefined status code");

    // Only frame-byte words carry a byte or a last marker
    a_nonbyte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_BYTE) |-> (o_frame_byte == 8'd0) && !o_last_of_frame)
        else $error("byte data on a status word");

    // Error and end words carry no chunk length
    a_errlen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ((o_status == ST_FORMAT) || (o_status == ST_END))
            |-> (o_chunk_length == 32'd0))
        else $error("chunk length on error or end word");

endmodule

bind avi_movi_video_chunk_demux_top avidmx_chk u_avidmx_chk (.*);
